// ===== sv/grkf_pkg.sv =====
package grkf_pkg;

    localparam int RAW_W    = 16;
    localparam int SAMPLE_W = 29;
    localparam int EST_W    = 32;
    localparam int COV_W    = 32;
    localparam int OUT_W    = 21;
    localparam int NOISE_W  = 15;
    localparam int NFIX_W   = 22;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // register index codes
    localparam logic [1:0] REG_RATE_OFFSET   = 2'd0;
    localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    localparam logic signed [RAW_W-1:0] RATE_OFFSET_RST   = -16'sd37;
    localparam logic [NOISE_W-1:0]      PROCESS_NOISE_RST = 15'd80;
    localparam logic [NOISE_W-1:0]      MEASURE_NOISE_RST = 15'd320;

    // sample scale: 65536*100/1638 = 4000 + 800/819, rounded via reciprocal of 819
    localparam logic [27:0] SCALE_INT   = 28'd4000;
    localparam logic [25:0] SCALE_FRAC  = 26'd800;
    localparam logic [25:0] SCALE_HALF  = 26'd409;
    localparam int          SCALE_PW    = 53;
    localparam logic [SCALE_PW-1:0] SCALE_RECIP = 53'd83906566;
    localparam int          SCALE_SHIFT = 36;
    localparam int          SCALE_Q_W   = 16;

    // noise scale: 65536/1000 = 65 + 536/1000, /1000 as >>3 then reciprocal of 125
    localparam logic [NFIX_W-1:0] NOISE_INT  = 22'd65;
    localparam logic [24:0]       NOISE_FRAC = 25'd536;
    localparam logic [24:0]       NOISE_HALF = 25'd500;
    localparam int                NOISE_PW   = 45;
    localparam logic [NOISE_PW-1:0] NOISE_RECIP = 45'd4294968;
    localparam int                NOISE_SHIFT = 29;
    localparam int                NOISE_Q_W   = 16;

    localparam logic [OUT_W-1:0] OUT_MAX     = 21'h0FFFFF;
    localparam logic [OUT_W-1:0] OUT_MIN     = 21'h100000;
    localparam logic [24:0]      OUT_LIM_POS = 25'd1048575;
    localparam logic [24:0]      OUT_LIM_NEG = 25'd1048576;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [NOISE_W-1:0] process_noise;
        logic [NOISE_W-1:0] measure_noise;
    } noise_cfg_t;

endpackage

// ===== sv/grkf_front.sv =====
module grkf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] raw_rate
    input  logic signed [grkf_pkg::RAW_W-1:0]   rate_offset,
    output logic                                push_valid,
    input  logic                                push_ready,
    output grkf_pkg::sample_t                   push_data
);
    import grkf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCALE = 2'd1;
    localparam logic [1:0] ST_RECIP = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic                  neg_reg;
    logic [16:0]           mag_reg;
    logic [25:0]           y_reg;
    logic [SCALE_Q_W-1:0]  q_reg;

    logic [16:0]           sum;
    logic [16:0]           mag;
    logic [SCALE_PW-1:0]   prod;
    logic [27:0]           mag_full;
    logic [SAMPLE_W-1:0]   mag_ext;

    assign sum  = {s_tdata[15], s_tdata} + {rate_offset[RAW_W-1], rate_offset};
    assign mag  = sum[16] ? (~sum + 17'd1) : sum;
    assign prod = SCALE_PW'(y_reg) * SCALE_RECIP;

    assign mag_full = 28'(mag_reg) * SCALE_INT + 28'(q_reg);
    assign mag_ext  = {1'b0, mag_full};

    assign s_tready   = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_data  = neg_reg ? sample_t'(~mag_ext + SAMPLE_W'(1)) : sample_t'(mag_ext);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RECIP;
            ST_RECIP: state_next = ST_PUSH;
            ST_PUSH:  if (push_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            neg_reg <= sum[16];
            mag_reg <= mag;
        end
        if (state_reg == ST_SCALE) begin
            y_reg <= 26'(mag_reg) * SCALE_FRAC + SCALE_HALF;
        end
        if (state_reg == ST_RECIP) begin
            q_reg <= prod[SCALE_SHIFT +: SCALE_Q_W];
        end
    end

endmodule

// ===== sv/grkf_queue.sv =====
module grkf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  grkf_pkg::sample_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output grkf_pkg::sample_t pop_data
);
    import grkf_pkg::*;

    sample_t     mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 2'd1;
        if (!do_push && do_pop) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/grkf_back.sv =====
module grkf_back #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  grkf_pkg::noise_cfg_t noise_cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  grkf_pkg::sample_t    pop_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [20:0] filtered_rate
);
    import grkf_pkg::*;

    localparam int G     = GAIN_FRAC_BITS;
    localparam int CNT_W = $clog2(G + 1);
    localparam logic [G:0]        ONE  = (G + 1)'(1) << G;
    localparam logic [EST_W+G-1:0] HALF = (EST_W + G)'(1) << (G - 1);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_PRED = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_MUL  = 3'd3;
    localparam logic [2:0] B_UPD  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg;

    // noise conversion pipeline
    logic [NOISE_W-1:0]     qn_reg, rn_reg;
    logic [24:0]            qy_reg, ry_reg;
    logic [NFIX_W-1:0]      qfix_reg, rfix_reg;
    logic [NOISE_W-1:0]     r_src;
    logic [NOISE_PW-1:0]    qprod, rprod;

    // filter state
    logic signed [EST_W-1:0] est_reg;
    logic [COV_W-1:0]        cov_reg;

    sample_t                sample_reg;
    logic [COV_W-1:0]       pmid_reg;
    logic [COV_W:0]         den_reg;
    logic [COV_W:0]         rem_reg;
    logic [G-1:0]           gain_reg;
    logic                   dneg_reg;
    logic [EST_W-1:0]       dmag_reg;
    logic [EST_W+G-1:0]     pstep_reg;
    logic [COV_W+G:0]       pcov_reg;

    logic                   ovalid_reg;
    logic [OUT_W-1:0]       odata_reg;

    logic [COV_W:0]         pred_sum;
    logic [COV_W-1:0]       pmid;
    logic [EST_W:0]         diff;
    logic [COV_W+1:0]       sh;
    logic                   ge;
    logic [G:0]             one_minus;
    logic [EST_W+G-1:0]     step_rnd;
    logic [EST_W-1:0]       step_mag;
    logic [EST_W:0]         step_ext;
    logic [EST_W:0]         x_sum;
    logic [EST_W:0]         xmag;
    logic [EST_W:0]         xrnd;
    logic [24:0]            omag;
    logic [OUT_W-1:0]       oval;
    logic                   out_free;

    assign r_src = (noise_cfg.measure_noise == '0) ? NOISE_W'(1) : noise_cfg.measure_noise;
    assign qprod = NOISE_PW'(qy_reg[24:3]) * NOISE_RECIP;
    assign rprod = NOISE_PW'(ry_reg[24:3]) * NOISE_RECIP;

    always_ff @(posedge aclk) begin
        qn_reg   <= noise_cfg.process_noise;
        rn_reg   <= r_src;
        qy_reg   <= 25'(noise_cfg.process_noise) * NOISE_FRAC + NOISE_HALF;
        ry_reg   <= 25'(r_src) * NOISE_FRAC + NOISE_HALF;
        qfix_reg <= NFIX_W'(qn_reg) * NOISE_INT + NFIX_W'(qprod[NOISE_SHIFT +: NOISE_Q_W]);
        rfix_reg <= NFIX_W'(rn_reg) * NOISE_INT + NFIX_W'(rprod[NOISE_SHIFT +: NOISE_Q_W]);
    end

    assign pred_sum = {1'b0, cov_reg} + (COV_W + 1)'(qfix_reg);
    assign pmid     = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];
    assign diff     = {{(EST_W + 1 - SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg}
                      - {est_reg[EST_W-1], est_reg};

    assign sh = {rem_reg, 1'b0};
    assign ge = (sh >= {1'b0, den_reg});

    assign one_minus = ONE - {1'b0, gain_reg};
    assign step_rnd  = pstep_reg + HALF;
    assign step_mag  = step_rnd[G +: EST_W];
    assign step_ext  = dneg_reg ? (~{1'b0, step_mag} + (EST_W + 1)'(1)) : {1'b0, step_mag};
    assign x_sum     = {est_reg[EST_W-1], est_reg} + step_ext;

    assign xmag = est_reg[EST_W-1] ? (~{est_reg[EST_W-1], est_reg} + (EST_W + 1)'(1))
                                   : {1'b0, est_reg};
    assign xrnd = xmag + (EST_W + 1)'(128);
    assign omag = xrnd[EST_W:8];

    always_comb begin
        if (est_reg[EST_W-1]) begin
            oval = (omag > OUT_LIM_NEG) ? OUT_MIN : OUT_W'(~omag + 25'd1);
        end else begin
            oval = (omag > OUT_LIM_POS) ? OUT_MAX : OUT_W'(omag);
        end
    end

    assign out_free  = !ovalid_reg || m_tready;
    assign pop_ready = (state_reg == B_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = {3'b000, odata_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (pop_valid) state_next = B_PRED;
            B_PRED:  state_next = B_DIV;
            B_DIV:   if (cnt_reg == CNT_W'(G - 1)) state_next = B_MUL;
            B_MUL:   state_next = B_UPD;
            B_UPD:   state_next = B_OUT;
            B_OUT:   if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            est_reg    <= '0;
            cov_reg    <= '0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_PRED) cnt_reg <= '0;
            if (state_reg == B_DIV)  cnt_reg <= cnt_reg + CNT_W'(1);
            if (state_reg == B_UPD) begin
                est_reg <= x_sum[EST_W-1:0];
                cov_reg <= pcov_reg[G +: COV_W];
            end
            if (state_reg == B_OUT && out_free) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && pop_valid) begin
            sample_reg <= pop_data;
        end
        if (state_reg == B_PRED) begin
            pmid_reg <= pmid;
            den_reg  <= {1'b0, pmid} + (COV_W + 1)'(rfix_reg);
            rem_reg  <= {1'b0, pmid};
            gain_reg <= '0;
            dneg_reg <= diff[EST_W];
            dmag_reg <= diff[EST_W] ? EST_W'(~diff + (EST_W + 1)'(1)) : diff[EST_W-1:0];
        end
        if (state_reg == B_DIV) begin
            rem_reg  <= ge ? (COV_W + 1)'(sh - {1'b0, den_reg}) : sh[COV_W:0];
            gain_reg <= {gain_reg[G-2:0], ge};
        end
        if (state_reg == B_MUL) begin
            pstep_reg <= (EST_W + G)'(dmag_reg) * (EST_W + G)'(gain_reg);
            pcov_reg  <= (COV_W + G + 1)'(pmid_reg) * (COV_W + G + 1)'(one_minus);
        end
        if (state_reg == B_OUT && out_free) begin
            odata_reg <= oval;
        end
    end

endmodule

// ===== sv/gyro_rate_kalman_filter.sv =====
// channel   direction  payload
// s_        in         raw_rate (16 bit signed gyro sample)
// m_        out        filtered_rate (21 bit signed, 1/256 deg/s)
// apb       in/out     rate_offset @0x0, process_noise @0x4, measure_noise @0x8
//
// front scales a sample in its SCALE and RECIP states and queues it (2 entries)
// back runs each sample through PRED, the bit-serial gain divider (DIV), MUL, UPD and OUT
// back accepts the next sample only when idle, after the last one has left OUT
// reset clears estimate and covariance and loads register defaults
// a stalled m_ side holds the result; front keeps filling the queue meanwhile
module gyro_rate_kalman_filter #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] raw_rate
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [20:0] filtered_rate
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grkf_pkg::APB_AW-1:0]   paddr,
    input  logic [grkf_pkg::APB_DW-1:0]   pwdata,
    output logic [grkf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import grkf_pkg::*;

    logic signed [RAW_W-1:0] offset_reg;
    logic [NOISE_W-1:0]      pnoise_reg;
    logic [NOISE_W-1:0]      mnoise_reg;
    noise_cfg_t              noise_cfg;

    logic    push_valid, push_ready, pop_valid, pop_ready;
    sample_t push_data, pop_data;

    assign pready = 1'b1;
    assign noise_cfg.process_noise = pnoise_reg;
    assign noise_cfg.measure_noise = mnoise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= RATE_OFFSET_RST;
            pnoise_reg <= PROCESS_NOISE_RST;
            mnoise_reg <= MEASURE_NOISE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_RATE_OFFSET:   offset_reg <= pwdata[RAW_W-1:0];
                REG_PROCESS_NOISE: pnoise_reg <= pwdata[NOISE_W-1:0];
                REG_MEASURE_NOISE: mnoise_reg <= pwdata[NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RATE_OFFSET:   prdata = {{(APB_DW - RAW_W){offset_reg[RAW_W-1]}}, offset_reg};
            REG_PROCESS_NOISE: prdata = APB_DW'(pnoise_reg);
            REG_MEASURE_NOISE: prdata = APB_DW'(mnoise_reg);
            default:           prdata = '0;
        endcase
    end

    grkf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .rate_offset (offset_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    grkf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    grkf_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .noise_cfg (noise_cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sim/testbench.sv =====
module testbench;

    import grkf_pkg::*;

    localparam int GAIN_BITS   = 16;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_PAUSE = 40;
    localparam int RAW_TARGET  = 1150;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata  = '0;    // [15:0] raw_rate
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;          // [20:0] filtered_rate
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    gyro_rate_kalman_filter #(
        .GAIN_FRAC_BITS(GAIN_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // filter state and register copies
    logic signed [RAW_W-1:0]   cfg_offset = RATE_OFFSET_RST;
    logic [NOISE_W-1:0]        cfg_pnoise = PROCESS_NOISE_RST;
    logic [NOISE_W-1:0]        cfg_mnoise = MEASURE_NOISE_RST;
    logic signed [EST_W-1:0]   est_q      = '0;
    logic [COV_W-1:0]          cov_q      = '0;

    logic [15:0]               raw_samples[$];
    logic [OUT_W-1:0]          expected_rates[$];

    bit  s_taken     = 1'b0;
    bit  src_steady  = 1'b0;
    bit  snk_steady  = 1'b0;
    int  src_gap     = 0;
    int  snk_hold    = 0;
    int  fail_count  = 0;
    int  samples_in  = 0;
    int  rates_out   = 0;
    int  settings_used = 1;
    int  idle_cycles = 0;

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [OUT_W-1:0] kalman_update(input logic signed [15:0] raw);
        longint          sum;
        longint          scaled;
        longint          diff;
        longint          corr;
        longint          nxt;
        longint          rate;
        longint unsigned qf;
        longint unsigned rf;
        longint unsigned pn;
        longint unsigned mn;
        longint unsigned pm;
        longint unsigned gain;
        longint unsigned one;
        sum    = longint'(raw) + longint'(cfg_offset);
        scaled = round_div(sum * 6553600, 1638);
        pn     = cfg_pnoise;
        mn     = (cfg_mnoise == '0) ? 1 : cfg_mnoise;
        qf     = (pn * 65536 + 500) / 1000;
        rf     = (mn * 65536 + 500) / 1000;
        pm     = cov_q;
        pm     = pm + qf;
        if (pm > 64'hFFFF_FFFF)
            pm = 64'hFFFF_FFFF;
        one    = 64'd1 << GAIN_BITS;
        gain   = (pm << GAIN_BITS) / (pm + rf);
        diff   = scaled - longint'(est_q);
        corr   = round_div(diff * longint'(gain), longint'(one));
        nxt    = longint'(est_q) + corr;
        if (nxt > 64'sd2147483647)
            nxt = 64'sd2147483647;
        if (nxt < -64'sd2147483648)
            nxt = -64'sd2147483648;
        est_q  = nxt[31:0];
        cov_q  = 32'((pm * (one - gain)) >> GAIN_BITS);
        rate   = round_div(nxt, 256);
        if (rate > 1048575)
            rate = 1048575;
        if (rate < -1048576)
            rate = -1048576;
        return rate[OUT_W-1:0];
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [15:0] random_raw();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3, 4: v = $urandom;
            default: v = int'($urandom_range(0, 800)) - 400;
        endcase
        return v[15:0];
    endfunction

    function automatic int random_noise(input int floor_val);
        case ($urandom_range(0, 9))
            0: return floor_val;
            1: return 32767;
            2, 3, 4: return $urandom_range(0, 32767);
            default: return $urandom_range(floor_val, 2000);
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            REG_RATE_OFFSET:   cfg_offset = value[15:0];
            REG_PROCESS_NOISE: cfg_pnoise = value[NOISE_W-1:0];
            REG_MEASURE_NOISE: cfg_mnoise = value[NOISE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_setting(input int offset, input int pnoise, input int mnoise);
        write_reg(REG_RATE_OFFSET, 32'(offset));
        write_reg(REG_PROCESS_NOISE, 32'(pnoise));
        write_reg(REG_MEASURE_NOISE, 32'(mnoise));
        settings_used++;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (raw_samples.size() != 0 || s_tvalid || expected_rates.size() != 0)
            @(posedge aclk);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else if (s_tvalid && !s_taken) begin
            s_tvalid <= 1'b1;
        end else if (src_gap > 0) begin
            s_tvalid <= 1'b0;
            src_gap--;
        end else if (raw_samples.size() > 0) begin
            s_tdata  <= raw_samples.pop_front();
            s_tvalid <= 1'b1;
            src_gap = pick_gap(src_steady);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result sink with random stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_hold = 0;
        end else if (snk_hold > 0) begin
            m_tready <= 1'b0;
            snk_hold--;
        end else begin
            m_tready <= 1'b1;
            snk_hold = pick_gap(snk_steady);
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        s_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                s_taken = 1'b1;
                expected_rates.push_back(kalman_update(s_tdata));
                samples_in++;
            end
            if (m_tvalid && m_tready) begin
                rates_out++;
                if (expected_rates.size() == 0) begin
                    $error("filtered_rate: expected nothing, got %0d",
                           $signed(m_tdata[OUT_W-1:0]));
                    fail_count++;
                end else begin
                    want = expected_rates.pop_front();
                    if (m_tdata[OUT_W-1:0] !== want) begin
                        $error("filtered_rate: expected %0d, got %0d",
                               $signed(want), $signed(m_tdata[OUT_W-1:0]));
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int len;
        int queued;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings, field extremes and values around the bias
        raw_samples.push_back(16'h0000);
        raw_samples.push_back(16'h7FFF);
        raw_samples.push_back(16'h8000);
        raw_samples.push_back(16'h0001);
        raw_samples.push_back(16'hFFFF);
        raw_samples.push_back(16'd37);
        raw_samples.push_back(16'd36);
        raw_samples.push_back(16'd38);
        raw_samples.push_back(16'h5555);
        raw_samples.push_back(16'hAAAA);
        wait_drained();

        // largest sum, near-unity gain
        apply_setting(32767, 32767, 1);
        raw_samples.push_back(16'h7FFF);
        raw_samples.push_back(16'h7FFF);
        raw_samples.push_back(16'h8000);
        raw_samples.push_back(16'h0000);
        wait_drained();

        // most negative sum, no process noise, heaviest measurement noise
        apply_setting(-32768, 0, 32767);
        raw_samples.push_back(16'h8000);
        raw_samples.push_back(16'h8000);
        raw_samples.push_back(16'h7FFF);
        wait_drained();

        // zero measurement noise treated as the smallest one
        apply_setting(0, 500, 0);
        raw_samples.push_back(16'd100);
        raw_samples.push_back(16'hFF9C);
        raw_samples.push_back(16'h0000);
        raw_samples.push_back(16'h7FFF);
        wait_drained();

        queued = samples_in;
        while (queued < RAW_TARGET) begin
            case ($urandom_range(0, 9))
                0: apply_setting(32767, random_noise(0), random_noise(0));
                1: apply_setting(-32768, random_noise(0), random_noise(1));
                2, 3, 4: apply_setting($urandom_range(0, 65535) - 32768,
                                       random_noise(0), random_noise(0));
                default: apply_setting(int'($urandom_range(0, 600)) - 300,
                                       random_noise(0), random_noise(1));
            endcase
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            len = $urandom_range(40, 200);
            if (queued + len > RAW_TARGET)
                len = RAW_TARGET - queued;
            repeat (len)
                raw_samples.push_back(random_raw());
            queued += len;
            wait_drained();
        end

        repeat (DRAIN_PAUSE) @(posedge aclk);
        $display("%0d gyro samples filtered, %0d rates checked", samples_in, rates_out);
        $display("%0d register settings applied, %0d mismatches", settings_used, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
